### hdl/bit_field_reader_assert.svh
// Assertion macros shared by the bit field reader RTL.
`ifndef BIT_FIELD_READER_ASSERT_SVH
`define BIT_FIELD_READER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define BFR_ASSERT_IMP(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("bit_field_reader assertion failed");

// Next-cycle implication, checked only while out of reset.
`define BFR_ASSERT_NXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("bit_field_reader assertion failed");

`endif

### hdl/bfr_pkg.sv
// Package with the types, codes and helper functions of the bit field reader.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

    // Word kinds on the request channel.
    localparam logic [1:0] REQ_FIELD = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_ALIGN = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_STRAY    = 2'd1;
    localparam logic [1:0] ST_BUSY     = 2'd2;
    localparam logic [1:0] ST_BADCOUNT = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] bit_count;
        logic       want_signed;
        logic [7:0] stream_byte;
    } req_word_t;

    typedef struct packed {
        logic [31:0] field_value;
        logic [1:0]  status;
    } rsp_word_t;

    typedef struct packed {
        logic [7:0]  leftover_bits;
        logic [2:0]  leftover_count;
        logic        request_pending;
        logic [5:0]  bits_still_needed;
        logic [5:0]  requested_width;
        logic        pending_signed;
        logic [31:0] partial_value;
    } rdr_state_t;

    // Mask with the low n bits set; saturates at all ones.
    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [31:0] m;
        if (n >= 6'd32)
        begin
            m = 32'hFFFF_FFFF;
        end
        else
        begin
            m = ~(32'hFFFF_FFFF << n);
        end
        return m;
    endfunction

    // Sign extension of a field of width w from its top bit.
    function automatic logic [31:0] sign_fix(input logic [31:0] v, input logic [5:0] w,
                                             input logic s);
        logic [4:0]  top;
        logic [31:0] r;
        top = 5'(w - 6'd1);
        r = v;
        if (s && (w != 6'd0) && (w <= 6'd32) && v[top])
        begin
            r = v | ~low_mask(w);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/bfr_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface bfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] bit_count;
    logic       want_signed;
    logic [7:0] stream_byte;

    modport source (output valid, output req_type, output bit_count, output want_signed,
                    output stream_byte, input ready);
    modport sink (input valid, input req_type, input bit_count, input want_signed,
                  input stream_byte, output ready);
endinterface

interface bfr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] field_value;
    logic [1:0]  status;

    modport source (output valid, output field_value, output status, input ready);
    modport sink (input valid, input field_value, input status, output ready);
endinterface

`default_nettype wire

### hdl/bfr_core.sv
// Combinational step of the reader: one word and the current state in, next state and result out.
`timescale 1ns / 1ps
`default_nettype none

module bfr_core #(
    parameter int MAX_FIELD_BITS = 32
) (
    input  wire bfr_pkg::req_word_t  word,
    input  wire bfr_pkg::rdr_state_t cur,
    output bfr_pkg::rdr_state_t      nxt,
    output logic                     has_rsp,
    output bfr_pkg::rsp_word_t       rsp
);

    logic [2:0]  imm_rest;
    logic [31:0] imm_val;
    logic [3:0]  take;
    logic [3:0]  byte_rest;
    logic [31:0] fin_val;

    always_comb
    begin
        imm_rest  = cur.leftover_count - word.bit_count[2:0];
        imm_val   = 32'(cur.leftover_bits >> imm_rest) & bfr_pkg::low_mask(word.bit_count);
        take      = cur.bits_still_needed[3:0];
        byte_rest = 4'd8 - take;
        fin_val   = (cur.partial_value << take) | 32'(word.stream_byte >> byte_rest);

        nxt     = cur;
        has_rsp = 1'b0;
        rsp     = '{field_value: 32'd0, status: bfr_pkg::ST_OK};

        unique case (word.req_type)
            bfr_pkg::REQ_FIELD:
            begin
                // Busy is checked before the count.
                if (cur.request_pending)
                begin
                    has_rsp    = 1'b1;
                    rsp.status = bfr_pkg::ST_BUSY;
                end
                else if (32'(word.bit_count) > 32'(MAX_FIELD_BITS))
                begin
                    has_rsp    = 1'b1;
                    rsp.status = bfr_pkg::ST_BADCOUNT;
                end
                else if (word.bit_count <= {3'd0, cur.leftover_count})
                begin
                    // Leftover bits cover the field: answer at once.
                    has_rsp = 1'b1;
                    rsp.field_value = bfr_pkg::sign_fix(imm_val, word.bit_count,
                                                        word.want_signed);
                    nxt.leftover_bits  = cur.leftover_bits &
                                         8'(bfr_pkg::low_mask({3'd0, imm_rest}));
                    nxt.leftover_count = imm_rest;
                end
                else
                begin
                    nxt.partial_value     = 32'(cur.leftover_bits);
                    nxt.bits_still_needed = word.bit_count - {3'd0, cur.leftover_count};
                    nxt.requested_width   = word.bit_count;
                    nxt.pending_signed    = word.want_signed;
                    nxt.leftover_bits     = 8'd0;
                    nxt.leftover_count    = 3'd0;
                    nxt.request_pending   = 1'b1;
                end
            end
            bfr_pkg::REQ_BYTE:
            begin
                if (!cur.request_pending)
                begin
                    has_rsp    = 1'b1;
                    rsp.status = bfr_pkg::ST_STRAY;
                end
                else if (cur.bits_still_needed > 6'd8)
                begin
                    nxt.partial_value     = {cur.partial_value[23:0], word.stream_byte};
                    nxt.bits_still_needed = cur.bits_still_needed - 6'd8;
                end
                else
                begin
                    // Final byte: one to eight bits complete the field.
                    has_rsp = 1'b1;
                    rsp.field_value = bfr_pkg::sign_fix(fin_val, cur.requested_width,
                                                        cur.pending_signed);
                    nxt.leftover_bits     = word.stream_byte &
                                            8'(bfr_pkg::low_mask({2'd0, byte_rest}));
                    nxt.leftover_count    = byte_rest[2:0];
                    nxt.request_pending   = 1'b0;
                    nxt.bits_still_needed = 6'd0;
                    nxt.partial_value     = 32'd0;
                end
            end
            bfr_pkg::REQ_ALIGN:
            begin
                nxt.leftover_bits  = 8'd0;
                nxt.leftover_count = 3'd0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/bit_field_reader.sv
// Top level of the MSB-first bit field reader.
//
//  channel | dir | modport    | words carried
//  --------+-----+------------+-------------------------------------------------
//  req     | in  | bfr_req_if | field request, stream byte or byte align
//  rsp     | out | bfr_rsp_if | field value with status (ok, stray, busy, count)
//
// Every word is handled in one combinational step, so one word per cycle is
// sustained while results are taken; a request is held in the input register
// and its result in the result register before the result handshake.
// That rate is set by the single combinational step in bfr_core between the
// input register and the reader state and result registers.
// Reset clears the reader state and both valid flags; no clearing pass is needed.
// A stalled result blocks only words that produce a result; bytes that feed a
// pending field and align words still move through.
`timescale 1ns / 1ps
`default_nettype none
`include "bit_field_reader_assert.svh"

module bit_field_reader #(
    parameter int MAX_FIELD_BITS = 32
) (
    input wire         clk,
    input wire         rst_n,
    bfr_req_if.sink    req,
    bfr_rsp_if.source  rsp
);

    // Input register: holds one accepted word until the processing stage takes it.
    logic               in_valid_reg;
    logic               in_valid_next;
    bfr_pkg::req_word_t in_word_reg;
    bfr_pkg::req_word_t in_word_next;

    // Reader state: leftover bits and the pending field.
    bfr_pkg::rdr_state_t state_reg;
    bfr_pkg::rdr_state_t state_next;
    bfr_pkg::rdr_state_t core_state;

    // Result register in front of the output channel.
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    bfr_pkg::rsp_word_t rsp_word_reg;
    bfr_pkg::rsp_word_t rsp_word_next;

    logic               core_has_rsp;
    bfr_pkg::rsp_word_t core_rsp;
    logic               rsp_free;
    logic               advance;
    logic               in_take;

    bfr_core #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_core (
        .word    (in_word_reg),
        .cur     (state_reg),
        .nxt     (core_state),
        .has_rsp (core_has_rsp),
        .rsp     (core_rsp)
    );

    // The result register is free when empty or when its word leaves this cycle.
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    // The held word is processed unless it makes a result that has nowhere to go.
    assign advance   = in_valid_reg && (!core_has_rsp || rsp_free);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_word_next  = '{req_type:    req.req_type,
                              bit_count:   req.bit_count,
                              want_signed: req.want_signed,
                              stream_byte: req.stream_byte};
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        state_next = advance ? core_state : state_reg;

        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (advance && core_has_rsp)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = core_rsp;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.field_value = rsp_word_reg.field_value;
    assign rsp.status      = rsp_word_reg.status;

    // A pending field has already consumed every leftover bit.
    `BFR_ASSERT_IMP(a_pending_no_leftover, clk, rst_n,
        state_reg.request_pending, state_reg.leftover_count == 3'd0)
    // A pending field always waits for at least one more bit.
    `BFR_ASSERT_IMP(a_pending_needs_bits, clk, rst_n,
        state_reg.request_pending, state_reg.bits_still_needed != 6'd0)
    // Leftover bits above the leftover count are always zero.
    `BFR_ASSERT_IMP(a_leftover_clean, clk, rst_n,
        1'b1, (state_reg.leftover_bits >> state_reg.leftover_count) == 8'd0)
    // Error results carry a zero field value.
    `BFR_ASSERT_IMP(a_error_zero_value, clk, rst_n,
        rsp_valid_reg && (rsp_word_reg.status != bfr_pkg::ST_OK),
        rsp_word_reg.field_value == 32'd0)

endmodule

`default_nettype wire
